### rtl/bsdcfb_pkg.sv
// Shared types, constants and helper functions for the dual-channel ring bridge.
package bsdcfb_pkg;

	// Ring geometry (2 .. 256 entries per ring)
	localparam int RING_DEPTH = 64;
	localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int ADDR_W     = IDX_W + 1;

	localparam logic [7:0] EMPTY_BYTE = 8'hFF;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [ADDR_W-1:0] addr_t;

	// Command codes carried by the request item
	typedef enum logic [2:0] {
		CMD_ADDRESS = 3'd0,
		CMD_MWRITE  = 3'd1,
		CMD_MREAD   = 3'd2,
		CMD_PUSH_TX = 3'd3,
		CMD_POP_RX  = 3'd4
	} cmd_e;

	typedef struct packed {
		logic [2:0] command;
		logic       channel;
		logic [7:0] data_byte;
	} req_item_t;

	typedef struct packed {
		logic [7:0] read_byte;
		logic       was_empty;
		logic       was_dropped;
		logic       current_channel;
	} rsp_item_t;

	// One access to a ring store
	typedef struct packed {
		logic       we;
		logic       re;
		addr_t      addr;
		logic [7:0] wdata;
	} ram_req_t;

	// What the result stage needs to finish an item
	typedef struct packed {
		logic       use_rdata;
		logic       from_rx;
		logic       was_empty;
		logic       was_dropped;
		logic       cur_chan;
		logic [7:0] byte_val;
	} res_info_t;

	// Advance a ring index with wrap at the ring depth
	function automatic idx_t next_idx(input idx_t i);
		return (i == idx_t'(RING_DEPTH - 1)) ? '0 : idx_t'(i + idx_t'(1));
	endfunction

	// Number of bytes held, (head - tail) modulo the ring depth
	function automatic idx_t fill_cnt(input idx_t h, input idx_t t);
		logic [IDX_W:0] sum;
		if (h >= t)
			sum = {1'b0, h} - {1'b0, t};
		else
			sum = {1'b0, h} + (IDX_W+1)'(RING_DEPTH) - {1'b0, t};
		return sum[IDX_W-1:0];
	endfunction

endpackage

### rtl/bsdcfb_ram.sv
// Generic single-port synchronous RAM with registered read data.
module bsdcfb_ram #(
	parameter int W  = 8,
	parameter int AW = 7
) (
	input  logic          clk,
	input  logic          we,
	input  logic          re,
	input  logic [AW-1:0] addr,
	input  logic [W-1:0]  wdata,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [2**AW];
	logic [W-1:0] rdata_q;

	// Write and registered read; never both in one cycle
	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		if (re)
			rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/bsdcfb_ctrl.sv
// Command decode, ring pointers and store access requests.
module bsdcfb_ctrl import bsdcfb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      accept,
	input  req_item_t item,
	output ram_req_t  tx_req,
	output ram_req_t  rx_req,
	output res_info_t info
);

	idx_t tx_head_q [2];
	idx_t tx_tail_q [2];
	idx_t rx_head_q [2];
	idx_t rx_tail_q [2];
	logic sel_q;

	logic     sel_nxt;
	logic     op_push;
	logic     op_pop;
	logic     op_count;
	logic     use_rx;
	logic     ch;
	idx_t     head;
	idx_t     tail;
	idx_t     cnt;
	logic     full;
	logic     empty;
	ram_req_t req;

	// Decode the command into a ring operation
	always_comb begin
		sel_nxt  = sel_q;
		op_push  = 1'b0;
		op_pop   = 1'b0;
		op_count = 1'b0;
		use_rx   = 1'b0;
		ch       = item.channel;
		case (item.command)
			CMD_ADDRESS: begin
				sel_nxt = item.data_byte[1];
			end
			CMD_MWRITE: begin
				op_push = 1'b1;
				use_rx  = 1'b1;
				ch      = sel_q;
			end
			CMD_MREAD: begin
				ch = 1'b1;
				if (sel_q)
					op_pop = 1'b1;
				else
					op_count = 1'b1;
			end
			CMD_PUSH_TX: begin
				op_push = 1'b1;
			end
			CMD_POP_RX: begin
				op_pop = 1'b1;
				use_rx = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Ring status of the addressed ring
	always_comb begin
		head  = use_rx ? rx_head_q[ch] : tx_head_q[ch];
		tail  = use_rx ? rx_tail_q[ch] : tx_tail_q[ch];
		cnt   = fill_cnt(head, tail);
		full  = (cnt == idx_t'(RING_DEPTH - 1));
		empty = (cnt == '0);
	end

	// Store access for the accepted item
	always_comb begin
		req.we    = accept & op_push & ~full;
		req.re    = accept & op_pop & ~empty;
		req.addr  = {ch, op_push ? head : tail};
		req.wdata = item.data_byte;
		tx_req    = req;
		rx_req    = req;
		tx_req.we = req.we & ~use_rx;
		tx_req.re = req.re & ~use_rx;
		rx_req.we = req.we & use_rx;
		rx_req.re = req.re & use_rx;
	end

	// Result information
	always_comb begin
		info.use_rdata   = op_pop & ~empty;
		info.from_rx     = use_rx;
		info.was_empty   = op_pop & empty;
		info.was_dropped = op_push & full;
		info.cur_chan    = sel_nxt;
		if (op_pop & empty)
			info.byte_val = EMPTY_BYTE;
		else if (op_count)
			info.byte_val = 8'(cnt);
		else
			info.byte_val = 8'h00;
	end

	// Pointer and channel-select registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q        <= 1'b0;
			tx_head_q[0] <= '0;
			tx_head_q[1] <= '0;
			tx_tail_q[0] <= '0;
			tx_tail_q[1] <= '0;
			rx_head_q[0] <= '0;
			rx_head_q[1] <= '0;
			rx_tail_q[0] <= '0;
			rx_tail_q[1] <= '0;
		end else if (accept) begin
			sel_q <= sel_nxt;
			if (req.we) begin
				if (use_rx)
					rx_head_q[ch] <= next_idx(head);
				else
					tx_head_q[ch] <= next_idx(head);
			end
			if (req.re) begin
				if (use_rx)
					rx_tail_q[ch] <= next_idx(tail);
				else
					tx_tail_q[ch] <= next_idx(tail);
			end
		end
	end

endmodule

### rtl/bus_slave_dual_channel_fifo_bridge_core.sv
// Top level of the dual-channel ring bridge: control, ring stores, result register.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+---------------------
//   request | req_valid | req_stall | req_item (req_item_t)
//   result  | rsp_valid | rsp_stall | rsp_item (rsp_item_t)
//
// An item passes the middle stage, then the result register: pointers update
// and the store is written or read on accept, and the registered read data is
// folded into the result register as the item leaves the middle stage. A new
// item can be accepted as the previous one moves into the result register.
// Reset clears pointers and channel select; ring contents stay undefined.
// A stalled result holds the middle stage, which then stalls requests.
module bus_slave_dual_channel_fifo_bridge_core import bsdcfb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_item_t req_item,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp_item
);

	ram_req_t  tx_req;
	ram_req_t  rx_req;
	res_info_t info;
	res_info_t info_s1;
	logic      valid_s1;
	logic      out_valid_q;
	rsp_item_t out_q;
	logic [7:0] tx_rdata;
	logic [7:0] rx_rdata;
	logic      accept;
	logic      move;

	assign move      = valid_s1 & (~out_valid_q | ~rsp_stall);
	assign req_stall = valid_s1 & ~move;
	assign accept    = req_valid & ~req_stall;

	bsdcfb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (req_item),
		.tx_req (tx_req),
		.rx_req (rx_req),
		.info   (info)
	);

	bsdcfb_ram #(.W(8), .AW(ADDR_W)) u_tx_ram (
		.clk   (clk),
		.we    (tx_req.we),
		.re    (tx_req.re),
		.addr  (tx_req.addr),
		.wdata (tx_req.wdata),
		.rdata (tx_rdata)
	);

	bsdcfb_ram #(.W(8), .AW(ADDR_W)) u_rx_ram (
		.clk   (clk),
		.we    (rx_req.we),
		.re    (rx_req.re),
		.addr  (rx_req.addr),
		.wdata (rx_req.wdata),
		.rdata (rx_rdata)
	);

	// Middle stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (move)
			valid_s1 <= 1'b0;
	end

	// Middle stage payload
	always_ff @(posedge clk) begin
		if (accept)
			info_s1 <= info;
	end

	// Result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (move)
			out_valid_q <= 1'b1;
		else if (~rsp_stall)
			out_valid_q <= 1'b0;
	end

	// Result register payload, read data folded in here
	always_ff @(posedge clk) begin
		if (move) begin
			if (info_s1.use_rdata)
				out_q.read_byte <= info_s1.from_rx ? rx_rdata : tx_rdata;
			else
				out_q.read_byte <= info_s1.byte_val;
			out_q.was_empty       <= info_s1.was_empty;
			out_q.was_dropped     <= info_s1.was_dropped;
			out_q.current_channel <= info_s1.cur_chan;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_item  = out_q;

endmodule

### rtl/bsdcfb_checker.sv
// Port-level checks for the dual-channel ring bridge, bound to the top level.
module bsdcfb_checker import bsdcfb_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      req_valid,
	input logic      req_stall,
	input logic      rsp_valid,
	input logic      rsp_stall,
	input rsp_item_t rsp_item
);

	// A stalled result stays put
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
		else $error("result changed while stalled");

	// An empty pop always returns the empty byte
	a_empty_byte: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_item.was_empty |-> rsp_item.read_byte == EMPTY_BYTE)
		else $error("empty pop without empty byte");

	// No item both pops and pushes
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_item.was_empty && rsp_item.was_dropped))
		else $error("empty and dropped flags together");

	// A dropped push reads nothing
	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_item.was_dropped |-> rsp_item.read_byte == 8'h00)
		else $error("dropped push returned data");

	// A result needs an accepted item that has passed the middle stage before it shows
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		!(req_valid && !req_stall) ##1 (!rsp_valid && !(req_valid && !req_stall))
		|=> !rsp_valid)
		else $error("result without an accepted item");

endmodule

bind bus_slave_dual_channel_fifo_bridge_core bsdcfb_checker u_bsdcfb_checker (.*);

### tb/sv/bsdcfb_reply_checker.sv
// Channel monitor for the dual-channel ring bridge: predicts each result and compares it.
`timescale 1ns / 100ps

module bsdcfb_reply_checker import bsdcfb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic      req_stall,
	input  req_item_t req_item,
	input  logic      rsp_valid,
	input  logic      rsp_stall,
	input  rsp_item_t rsp_item,
	output int        replies_owed,
	output int        mismatch_count
);

	localparam int TX_SIDE    = 0;
	localparam int RX_SIDE    = 1;
	localparam int PRINT_CAP  = 40;

	// Shadow rings, indexed [side][channel]
	logic [7:0] ring_mem  [2][2][RING_DEPTH];
	idx_t       ring_head [2][2];
	idx_t       ring_tail [2][2];
	logic       sel_chan;

	rsp_item_t  pending_replies [$];
	rsp_item_t  want;

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("%0t ns: result mismatch: %s", $time, what);
	endtask

	function automatic int ring_fill(input int s, input int c);
		int h;
		int t;
		h = ring_head[s][c];
		t = ring_tail[s][c];
		return (h >= t) ? h - t : h + RING_DEPTH - t;
	endfunction

	function automatic idx_t wrap_inc(input idx_t i);
		return (int'(i) == RING_DEPTH - 1) ? '0 : idx_t'(int'(i) + 1);
	endfunction

	// Returns 1 when the ring is full and the byte is lost
	function automatic logic ring_push(input int s, input int c, input logic [7:0] v);
		if (ring_fill(s, c) >= RING_DEPTH - 1)
			return 1'b1;
		ring_mem[s][c][ring_head[s][c]] = v;
		ring_head[s][c] = wrap_inc(ring_head[s][c]);
		return 1'b0;
	endfunction

	// Returns 1 when the ring is empty; v then carries the empty marker
	function automatic logic ring_pop(input int s, input int c, output logic [7:0] v);
		if (ring_fill(s, c) == 0) begin
			v = EMPTY_BYTE;
			return 1'b1;
		end
		v = ring_mem[s][c][ring_tail[s][c]];
		ring_tail[s][c] = wrap_inc(ring_tail[s][c]);
		return 1'b0;
	endfunction

	// Advance the shadow state by one request and build the result it should give
	function automatic rsp_item_t predict_reply(input req_item_t rq);
		rsp_item_t  r;
		logic [7:0] rb;
		r = '0;
		case (rq.command)
			CMD_ADDRESS: sel_chan = rq.data_byte[1];
			CMD_MWRITE:  r.was_dropped = ring_push(RX_SIDE, int'(sel_chan), rq.data_byte);
			CMD_MREAD: begin
				// channel 0 reports the fill of channel 1's transmit ring
				if (!sel_chan) begin
					r.read_byte = 8'(ring_fill(TX_SIDE, 1));
				end else begin
					r.was_empty = ring_pop(TX_SIDE, 1, rb);
					r.read_byte = rb;
				end
			end
			CMD_PUSH_TX: r.was_dropped = ring_push(TX_SIDE, int'(rq.channel), rq.data_byte);
			CMD_POP_RX: begin
				r.was_empty = ring_pop(RX_SIDE, int'(rq.channel), rb);
				r.read_byte = rb;
			end
			default: ;
		endcase
		r.current_channel = sel_chan;
		return r;
	endfunction

	// Results are retired before new requests: a result never belongs to
	// a request accepted at the same edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_chan = 1'b0;
			foreach (ring_head[s, c]) begin
				ring_head[s][c] = '0;
				ring_tail[s][c] = '0;
			end
			pending_replies.delete();
			replies_owed <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (pending_replies.size() == 0) begin
					report_mismatch($sformatf("result %h with no request pending", rsp_item));
				end else begin
					want = pending_replies.pop_front();
					if (rsp_item.read_byte !== want.read_byte)
						report_mismatch($sformatf("read_byte %h, expected %h",
							rsp_item.read_byte, want.read_byte));
					if (rsp_item.was_empty !== want.was_empty)
						report_mismatch($sformatf("was_empty %b, expected %b",
							rsp_item.was_empty, want.was_empty));
					if (rsp_item.was_dropped !== want.was_dropped)
						report_mismatch($sformatf("was_dropped %b, expected %b",
							rsp_item.was_dropped, want.was_dropped));
					if (rsp_item.current_channel !== want.current_channel)
						report_mismatch($sformatf("current_channel %b, expected %b",
							rsp_item.current_channel, want.current_channel));
				end
			end
			if (req_valid && !req_stall)
				pending_replies.push_back(predict_reply(req_item));
			replies_owed <= pending_replies.size();
		end
	end

endmodule

### tb/sv/bus_slave_dual_channel_fifo_bridge_core_tb.sv
// Testbench top for the dual-channel ring bridge: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module bus_slave_dual_channel_fifo_bridge_core_tb;
	import bsdcfb_pkg::*;

	localparam logic [2:0] CMD_LAST_CODE   = 3'd7;
	localparam int         PHASES          = 4;
	localparam int         ITEMS_PER_PHASE = 155;
	localparam int         SETTLE_CYCLES   = 10;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_item_t req_item  = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_item_t rsp_item;
	int        replies_owed;
	int        mismatch_count;

	int send_idle_pct = 0;
	int stall_pct     = 0;

	// Idling mix per phase: none, sender, receiver, both lightly
	int phase_send  [PHASES] = '{0, 81, 0, 10};
	int phase_stall [PHASES] = '{0, 0, 81, 10};

	bus_slave_dual_channel_fifo_bridge_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_item  (req_item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_item  (rsp_item)
	);

	bsdcfb_reply_checker u_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.req_item       (req_item),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.rsp_item       (rsp_item),
		.replies_owed   (replies_owed),
		.mismatch_count (mismatch_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver back-pressure
	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// Offer one item, with random idle cycles ahead of it, and hold it until taken
	task automatic send_item(input logic [2:0] cmd, input logic ch, input logic [7:0] data);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_item  <= '{command: cmd, channel: ch, data_byte: data};
		do @(posedge clk); while (req_stall);
	endtask

	// Hold off the sender until every outstanding result has come back
	task automatic wait_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (replies_owed != 0);
	endtask

	// Bursts that fill or empty a ring, mixed with short runs of anything
	task automatic random_phase(input int n_items);
		int   done;
		int   kind;
		int   len;
		int   i;
		logic ch;
		done = 0;
		while (done < n_items) begin
			kind = $urandom_range(0, 9);
			len  = $urandom_range(50, 80);
			ch   = 1'($urandom);
			case (kind)
				0: begin
					// local transmit pushes, which can run long enough to overflow
					for (i = 0; i < len; i++)
						send_item(CMD_PUSH_TX, ch, 8'($urandom));
				end
				1: begin
					// select a channel, then flood its receive ring from the bus side
					send_item(CMD_ADDRESS, 1'($urandom), {6'($urandom), ch, 1'($urandom)});
					for (i = 0; i < len; i++)
						send_item(CMD_MWRITE, 1'($urandom), 8'($urandom));
				end
				2: begin
					// local receive pops, past empty
					for (i = 0; i < len; i++)
						send_item(CMD_POP_RX, ch, 8'($urandom));
				end
				3: begin
					// bus reads on channel 1 drain the channel 1 transmit ring
					send_item(CMD_ADDRESS, 1'($urandom), {6'($urandom), 1'b1, 1'($urandom)});
					for (i = 0; i < len; i++)
						send_item(CMD_MREAD, 1'($urandom), 8'($urandom));
				end
				default: begin
					len = $urandom_range(4, 16);
					for (i = 0; i < len; i++)
						send_item(3'($urandom_range(0, CMD_LAST_CODE)), 1'($urandom),
							8'($urandom));
				end
			endcase
			done += len;
		end
	endtask

	initial begin
		int p;
		int c;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty reads, channel select, field extremes, spare codes
		send_item(CMD_MREAD,   1'b1, 8'hFF);   // channel 0 count of an empty ring
		send_item(CMD_POP_RX,  1'b0, 8'h00);   // empty receive pop
		send_item(CMD_POP_RX,  1'b1, 8'hFF);
		send_item(CMD_ADDRESS, 1'b0, 8'h02);   // select channel 1
		send_item(CMD_MREAD,   1'b0, 8'h00);   // pop from empty transmit ring
		send_item(CMD_PUSH_TX, 1'b1, 8'h00);
		send_item(CMD_PUSH_TX, 1'b1, 8'hFF);
		send_item(CMD_PUSH_TX, 1'b0, 8'hA5);
		send_item(CMD_MREAD,   1'b1, 8'h55);   // pops the first byte
		send_item(CMD_ADDRESS, 1'b1, 8'hFD);   // bit 1 clear selects channel 0
		send_item(CMD_MREAD,   1'b0, 8'hFF);   // count of one
		send_item(CMD_MWRITE,  1'b1, 8'hFF);
		send_item(CMD_MWRITE,  1'b0, 8'h00);
		send_item(CMD_ADDRESS, 1'b0, 8'hFF);
		send_item(CMD_MWRITE,  1'b0, 8'h5A);
		send_item(CMD_POP_RX,  1'b0, 8'h00);
		send_item(CMD_POP_RX,  1'b0, 8'hFF);
		send_item(CMD_POP_RX,  1'b1, 8'h00);
		send_item(CMD_POP_RX,  1'b1, 8'h00);
		for (c = int'(CMD_POP_RX) + 1; c <= int'(CMD_LAST_CODE); c++)
			send_item(3'(c), 1'b1, 8'hFF);
		send_item(CMD_ADDRESS, 1'b1, 8'h00);
		wait_drained();

		for (p = 0; p < PHASES; p++) begin
			send_idle_pct = phase_send[p];
			stall_pct     = phase_stall[p];
			random_phase(ITEMS_PER_PHASE);
			wait_drained();
		end

		stall_pct = 0;
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("[bus_slave_dual_channel_fifo_bridge_core] OK");
		end else begin
			$display("[bus_slave_dual_channel_fifo_bridge_core] ERROR");
		end
		$finish;
	end

	// Run limit
	initial begin
		#5_000_000;
		$display("[bus_slave_dual_channel_fifo_bridge_core] ERROR");
		$finish;
	end

endmodule

### filelist.f
rtl/bsdcfb_pkg.sv
rtl/bsdcfb_ram.sv
rtl/bsdcfb_ctrl.sv
rtl/bus_slave_dual_channel_fifo_bridge_core.sv
rtl/bsdcfb_checker.sv
tb/sv/bsdcfb_reply_checker.sv
tb/sv/bus_slave_dual_channel_fifo_bridge_core_tb.sv
